[design/timed_step_sequence_player_assert.svh]
// ----------------------------------------------------------------------------
// Timed step sequence player assertion macros
// Shared property forms for the checker of the step sequence player.
// ----------------------------------------------------------------------------
`ifndef TIMED_STEP_SEQUENCE_PLAYER_ASSERT_SVH
`define TIMED_STEP_SEQUENCE_PLAYER_ASSERT_SVH

// same-cycle implication
`define TSPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSPP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tspp_pkg.sv]
// ----------------------------------------------------------------------------
// Timed step sequence player package
// Item codes, drive verbs, register indexes and the step entry type.
// ----------------------------------------------------------------------------
package tspp_pkg;

  localparam int MAX_STEPS_DEF = 16;

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_PLAY  = 3'd2;
  localparam logic [2:0] OP_STOP  = 3'd3;
  localparam logic [2:0] OP_BRAKE = 3'd4;

  localparam logic [2:0] VERB_BRAKE = 3'd6;
  localparam logic [2:0] VERB_COAST = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_SEQ_LEN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_TARGET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_FOREVER = 2'd2;

  typedef struct packed {
    logic [2:0]  verb;
    logic [7:0]  speed;
    logic [31:0] duration;
  } step_entry_t;

  function automatic logic is_stop_verb(input logic [2:0] verb);
    return (verb == VERB_BRAKE) || (verb == VERB_COAST);
  endfunction

endpackage

[design/timed_step_sequence_player.sv]
// ----------------------------------------------------------------------------
// Timed step sequence player with a two-entry output buffer: result registered
// in the output or skid register, one item per cycle while the output does not
// stall, set by the next-state logic and one-step-ahead step memory prefetch.
// Synchronous active-low reset clears control state and table valid bits.
// ----------------------------------------------------------------------------
module timed_step_sequence_player #(
  parameter int MAX_STEPS = tspp_pkg::MAX_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [tspp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tspp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // slot[3:0], step_verb[6:4], step_speed[14:7], step_duration[46:15], zero
  input  logic [tspp_pkg::IN_DATA_W-1:0]   in_tdata,
  // op[2:0]
  input  logic [tspp_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // cmd_verb[2:0], cmd_speed[10:3], playing[11], current_step[15:12],
  // loops_done[23:16], rejected[24], zero
  output logic [tspp_pkg::OUT_DATA_W-1:0]  out_tdata,
  // cmd_valid[0]
  output logic [tspp_pkg::OUT_USER_W-1:0]  out_tuser
);

  localparam int PW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  typedef struct packed {
    logic [tspp_pkg::OUT_DATA_W-1:0] data;
    logic [tspp_pkg::OUT_USER_W-1:0] user;
  } result_t;

  // configuration
  logic [4:0] seq_len_r;
  logic [7:0] loop_target_r;
  logic       loop_forever_r;

  // play state
  logic                  active_r, active_nxt;
  logic [PW-1:0]         ptr_r, ptr_nxt;
  logic [PW-1:0]         last_r, last_nxt;
  logic [7:0]            pass_r, pass_nxt;
  logic [7:0]            target_r, target_nxt;
  logic                  forever_r, forever_nxt;
  logic [31:0]           elapsed_r, elapsed_nxt;
  tspp_pkg::step_entry_t cur_r, cur_nxt;
  tspp_pkg::step_entry_t nxt_r, nxt_nxt;
  tspp_pkg::step_entry_t e0_r, e0_nxt;
  tspp_pkg::step_entry_t e1_r, e1_nxt;

  // step memory
  tspp_pkg::step_entry_t mem [MAX_STEPS];
  logic [MAX_STEPS-1:0]  vld_r;
  tspp_pkg::step_entry_t rd_q_r;
  logic                  rd_vld_r;
  tspp_pkg::step_entry_t mem_ent;
  logic [PW-1:0]         rd_addr;
  logic                  wr_en;
  logic [PW-1:0]         wr_idx;
  tspp_pkg::step_entry_t wr_data;

  // output buffer
  result_t out_r, skid_r, res;
  logic    out_vld_r, skid_vld_r;

  logic                  in_fire, pop;
  logic [2:0]            op;
  logic [3:0]            slot;
  tspp_pkg::step_entry_t in_ent;
  logic [8:0]            len_clamp;
  logic [31:0]           el_inc;
  logic [7:0]            pass_inc;
  logic                  cmd_valid, rejected;
  logic [2:0]            cmd_verb;
  logic [7:0]            cmd_speed;

  function automatic logic [PW-1:0] succ(input logic [PW-1:0] p, input logic [PW-1:0] lst);
    return (p == lst) ? '0 : PW'(p + PW'(1));
  endfunction

  assign in_tready = !skid_vld_r;
  assign in_fire   = in_tvalid && in_tready;
  assign pop       = out_vld_r && out_tready;

  assign op              = in_tuser[2:0];
  assign slot            = in_tdata[3:0];
  assign in_ent.verb     = in_tdata[6:4];
  assign in_ent.speed    = in_tdata[14:7];
  assign in_ent.duration = in_tdata[46:15];

  assign mem_ent   = rd_vld_r ? rd_q_r : '0;
  assign len_clamp = (9'(seq_len_r) > 9'(MAX_STEPS)) ? 9'(MAX_STEPS) : 9'(seq_len_r);
  assign el_inc    = (elapsed_r == 32'hFFFF_FFFF) ? elapsed_r : elapsed_r + 32'd1;
  assign pass_inc  = pass_r + 8'd1;
  assign rd_addr   = succ(succ(ptr_nxt, last_nxt), last_nxt);
  assign wr_data   = in_ent;
  assign wr_idx    = PW'(slot);

  always_comb begin
    active_nxt  = active_r;
    ptr_nxt     = ptr_r;
    last_nxt    = last_r;
    pass_nxt    = pass_r;
    target_nxt  = target_r;
    forever_nxt = forever_r;
    elapsed_nxt = elapsed_r;
    cur_nxt     = cur_r;
    nxt_nxt     = nxt_r;
    e0_nxt      = e0_r;
    e1_nxt      = e1_r;
    wr_en       = 1'b0;
    cmd_valid   = 1'b0;
    cmd_verb    = '0;
    cmd_speed   = '0;
    rejected    = 1'b0;
    if (in_fire) begin
      case (op)
        tspp_pkg::OP_TICK: begin
          if (active_r && (tspp_pkg::is_stop_verb(cur_r.verb) || cur_r.duration != '0)) begin
            elapsed_nxt = el_inc;
            if (el_inc >= cur_r.duration) begin
              if (ptr_r != last_r || forever_r || pass_inc < target_r) begin
                if (ptr_r == last_r) begin
                  pass_nxt = pass_inc;
                end
                ptr_nxt     = succ(ptr_r, last_r);
                elapsed_nxt = '0;
                cur_nxt     = nxt_r;
                nxt_nxt     = mem_ent;
                cmd_valid   = 1'b1;
                cmd_verb    = nxt_r.verb;
                cmd_speed   = tspp_pkg::is_stop_verb(nxt_r.verb) ? 8'd0 : nxt_r.speed;
              end else begin
                pass_nxt   = pass_inc;
                active_nxt = 1'b0;
                if (!tspp_pkg::is_stop_verb(cur_r.verb)) begin
                  cmd_valid = 1'b1;
                  cmd_verb  = tspp_pkg::VERB_COAST;
                end
              end
            end
          end
        end
        tspp_pkg::OP_LOAD: begin
          if (active_r) begin
            rejected = 1'b1;
          end else if (9'(slot) < 9'(MAX_STEPS)) begin
            wr_en = 1'b1;
            if (slot == 4'd0) begin
              e0_nxt = in_ent;
            end
            if (slot == 4'd1) begin
              e1_nxt = in_ent;
            end
          end
        end
        tspp_pkg::OP_PLAY: begin
          if (len_clamp == '0) begin
            rejected = 1'b1;
          end else begin
            last_nxt    = PW'(len_clamp - 9'd1);
            target_nxt  = loop_target_r;
            forever_nxt = loop_forever_r;
            ptr_nxt     = '0;
            pass_nxt    = '0;
            elapsed_nxt = '0;
            active_nxt  = 1'b1;
            cur_nxt     = e0_r;
            nxt_nxt     = (len_clamp == 9'd1) ? e0_r : e1_r;
            cmd_valid   = 1'b1;
            cmd_verb    = e0_r.verb;
            cmd_speed   = tspp_pkg::is_stop_verb(e0_r.verb) ? 8'd0 : e0_r.speed;
          end
        end
        tspp_pkg::OP_STOP: begin
          active_nxt = 1'b0;
          cmd_valid  = 1'b1;
          cmd_verb   = tspp_pkg::VERB_COAST;
        end
        tspp_pkg::OP_BRAKE: begin
          active_nxt = 1'b0;
          cmd_valid  = 1'b1;
          cmd_verb   = tspp_pkg::VERB_BRAKE;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.user = cmd_valid;
    res.data = {7'd0, rejected, pass_nxt, 4'(ptr_nxt), active_nxt, cmd_speed, cmd_verb};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r      <= '0;
      loop_target_r  <= 8'd1;
      loop_forever_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tspp_pkg::REG_SEQ_LEN:      seq_len_r      <= cfg_wdata[4:0];
        tspp_pkg::REG_LOOP_TARGET:  loop_target_r  <= cfg_wdata;
        tspp_pkg::REG_LOOP_FOREVER: loop_forever_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      ptr_r     <= '0;
      last_r    <= '0;
      pass_r    <= '0;
      target_r  <= 8'd1;
      forever_r <= 1'b0;
      elapsed_r <= '0;
      cur_r     <= '0;
      nxt_r     <= '0;
      e0_r      <= '0;
      e1_r      <= '0;
      vld_r     <= '0;
    end else begin
      active_r  <= active_nxt;
      ptr_r     <= ptr_nxt;
      last_r    <= last_nxt;
      pass_r    <= pass_nxt;
      target_r  <= target_nxt;
      forever_r <= forever_nxt;
      elapsed_r <= elapsed_nxt;
      cur_r     <= cur_nxt;
      nxt_r     <= nxt_nxt;
      e0_r      <= e0_nxt;
      e1_r      <= e1_nxt;
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (pop) begin
      if (skid_vld_r) begin
        out_r      <= skid_r;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= in_fire;
        out_r     <= res;
      end
    end else if (!out_vld_r) begin
      out_vld_r <= in_fire;
      out_r     <= res;
    end else if (in_fire) begin
      skid_r     <= res;
      skid_vld_r <= 1'b1;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r.data;
  assign out_tuser  = out_r.user;

endmodule

[design/tspp_checker.sv]
// ----------------------------------------------------------------------------
// Timed step sequence player port checker
// Watches the result channel for handshake and command encoding rules.
// ----------------------------------------------------------------------------
`include "timed_step_sequence_player_assert.svh"

module tspp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tspp_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [tspp_pkg::OUT_USER_W-1:0] out_tuser
);

  `TSPP_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled transfer changed")
  `TSPP_ASSERT_IMP(a_rej_no_cmd, clk, rst_n, out_tvalid && out_tdata[24], !out_tuser[0], "rejected item carries a command")
  `TSPP_ASSERT_IMP(a_stop_speed, clk, rst_n, out_tvalid && (out_tdata[2:0] == tspp_pkg::VERB_BRAKE || out_tdata[2:0] == tspp_pkg::VERB_COAST), out_tdata[10:3] == 8'd0, "brake or coast with speed")
  `TSPP_ASSERT_IMP(a_idle_cmd, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata[10:0] == 11'd0, "command fields set without command")

endmodule

bind timed_step_sequence_player tspp_checker u_tspp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Step sequence player testbench
// Loads drive step tables, plays them with tick items and checks every result
// transfer against a cycle-free model of the player or a row's expectation.
// A short directed table comes first, then random phases of table load, play
// and ticks mixed with stray items, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ITEMS = 1900;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TABLE_DEPTH = tspp_pkg::MAX_STEPS_DEF;

  localparam logic [2:0] OP_RSV_LO  = 3'd5;
  localparam logic [2:0] OP_RSV_MID = 3'd6;
  localparam logic [2:0] OP_RSV_HI  = 3'd7;

  localparam logic [2:0] VERB_FWD     = 3'd0;
  localparam logic [2:0] VERB_TURN_L  = 3'd2;
  localparam logic [2:0] VERB_PIVOT_R = 3'd5;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] verb;
    logic [7:0] speed;
    logic       playing;
    logic [3:0] step;
    logic [7:0] loops;
    logic       rejected;
  } drive_result_t;

  typedef struct packed {
    logic          is_reg_write;
    logic [2:0]    op;
    logic [3:0]    slot;
    logic [2:0]    verb;
    logic [7:0]    speed;
    logic [31:0]   dur;
    logic          has_exp;
    drive_result_t exp;
    logic [4:0]    seq_len;
    logic [7:0]    loop_tgt;
    logic          loop_fwd;
  } plan_row_t;

  localparam drive_result_t QUIET = '0;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_wr_en;
  logic [tspp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tspp_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [tspp_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [tspp_pkg::IN_USER_W-1:0]  in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [tspp_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [tspp_pkg::OUT_USER_W-1:0] out_tuser;

  // player model state
  tspp_pkg::step_entry_t step_mem [TABLE_DEPTH];
  bit                    running;
  int                    cur_step;
  logic [7:0]            loop_cnt;
  logic [31:0]           elapsed;
  logic [4:0]            reg_len;
  logic [7:0]            reg_tgt;
  logic                  reg_fwd;
  int                    run_len;
  logic [7:0]            run_tgt;
  logic                  run_fwd;

  drive_result_t pending_cmds[$];
  plan_row_t     plan[$];
  bit            row_has_exp;
  drive_result_t row_exp;
  int            fail_cnt;
  int            results_seen;
  int            cycles;
  int            sent;
  bit            calm_in;
  bit            calm_out;
  bit            calm_end;

  timed_step_sequence_player DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic bit ends_motion(input logic [2:0] v);
    return (v == tspp_pkg::VERB_BRAKE) || (v == tspp_pkg::VERB_COAST);
  endfunction

  function automatic drive_result_t step_cmd(input tspp_pkg::step_entry_t e);
    drive_result_t r;
    r = '0;
    r.cmd_valid = 1'b1;
    r.verb = e.verb;
    r.speed = ends_motion(e.verb) ? 8'd0 : e.speed;
    return r;
  endfunction

  function automatic drive_result_t predict_player(input logic [2:0] op, input logic [3:0] slot,
                                                   input tspp_pkg::step_entry_t ld);
    drive_result_t         r;
    tspp_pkg::step_entry_t cur;
    logic                  rej;
    int                    len;
    r = '0;
    rej = 1'b0;
    case (op)
      tspp_pkg::OP_TICK: begin
        cur = step_mem[cur_step];
        if (running && (ends_motion(cur.verb) || cur.duration != 32'd0)) begin
          if (elapsed != 32'hFFFF_FFFF) elapsed = elapsed + 32'd1;
          if (elapsed >= cur.duration) begin
            if (cur_step + 1 < run_len) begin
              cur_step = cur_step + 1;
              elapsed = '0;
              r = step_cmd(step_mem[cur_step]);
            end else begin
              loop_cnt = loop_cnt + 8'd1;
              if (run_fwd || loop_cnt < run_tgt) begin
                cur_step = 0;
                elapsed = '0;
                r = step_cmd(step_mem[0]);
              end else begin
                running = 1'b0;
                if (!ends_motion(step_mem[run_len-1].verb))
                  r = step_cmd({tspp_pkg::VERB_COAST, 8'd0, 32'd0});
              end
            end
          end
        end
      end
      tspp_pkg::OP_LOAD: begin
        if (running) rej = 1'b1;
        else step_mem[slot] = ld;
      end
      tspp_pkg::OP_PLAY: begin
        len = (int'(reg_len) > TABLE_DEPTH) ? TABLE_DEPTH : int'(reg_len);
        if (len == 0) begin
          rej = 1'b1;
        end else begin
          run_len = len;
          run_tgt = reg_tgt;
          run_fwd = reg_fwd;
          cur_step = 0;
          loop_cnt = '0;
          elapsed = '0;
          running = 1'b1;
          r = step_cmd(step_mem[0]);
        end
      end
      tspp_pkg::OP_STOP: begin
        running = 1'b0;
        r = step_cmd({tspp_pkg::VERB_COAST, 8'd0, 32'd0});
      end
      tspp_pkg::OP_BRAKE: begin
        running = 1'b0;
        r = step_cmd({tspp_pkg::VERB_BRAKE, 8'd0, 32'd0});
      end
      default: ;
    endcase
    r.playing = running;
    r.step = cur_step[3:0];
    r.loops = loop_cnt;
    r.rejected = rej;
    return r;
  endfunction

  function automatic drive_result_t res(input int v, input int verb, input int speed,
                                        input int playing, input int step, input int loops,
                                        input int rej);
    return {1'(v), 3'(verb), 8'(speed), 1'(playing), 4'(step), 8'(loops), 1'(rej)};
  endfunction

  function automatic plan_row_t item_row(input logic [2:0] op, input logic [3:0] slot,
                                         input logic [2:0] verb, input logic [7:0] speed,
                                         input logic [31:0] dur, input logic has_exp,
                                         input drive_result_t exp);
    plan_row_t p;
    p = '0;
    p.op = op;
    p.slot = slot;
    p.verb = verb;
    p.speed = speed;
    p.dur = dur;
    p.has_exp = has_exp;
    p.exp = exp;
    return p;
  endfunction

  function automatic plan_row_t reg_row(input logic [4:0] len, input logic [7:0] tgt,
                                        input logic fwd);
    plan_row_t p;
    p = '0;
    p.is_reg_write = 1'b1;
    p.seq_len = len;
    p.loop_tgt = tgt;
    p.loop_fwd = fwd;
    return p;
  endfunction

  // one transfer on the input stream; returns at the falling edge after it
  task automatic send_item(input logic [2:0] op, input logic [3:0] slot, input logic [2:0] verb,
                           input logic [7:0] speed, input logic [31:0] dur,
                           input logic has_exp, input drive_result_t exp);
    if (!calm_end && !calm_in && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    if ($urandom_range(0, 63) == 0) calm_in = !calm_in;
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = {1'b0, dur, speed, verb, slot};
    row_has_exp = has_exp;
    row_exp = exp;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent++;
  endtask

  // hold the input side until every result is back
  task automatic settle();
    in_tvalid = 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_regs(input logic [4:0] len, input logic [7:0] tgt, input logic fwd);
    cfg_wr_en = 1'b1;
    cfg_index = tspp_pkg::REG_SEQ_LEN;
    cfg_wdata = {3'b000, len};
    @(negedge clk);
    cfg_index = tspp_pkg::REG_LOOP_TARGET;
    cfg_wdata = tgt;
    @(negedge clk);
    cfg_index = tspp_pkg::REG_LOOP_FOREVER;
    cfg_wdata = {7'd0, fwd};
    @(negedge clk);
    cfg_wr_en = 1'b0;
    reg_len = len;
    reg_tgt = tgt;
    reg_fwd = fwd;
  endtask

  always @(posedge clk) begin : monitor
    drive_result_t got;
    drive_result_t want;
    if (rst_n) begin
      cycles++;
      if (out_tvalid && out_tready) begin
        got = {out_tuser[0], out_tdata[2:0], out_tdata[10:3], out_tdata[11],
               out_tdata[15:12], out_tdata[23:16], out_tdata[24]};
        results_seen++;
        if (pending_cmds.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("result %0d: transfer with nothing expected (tdata=%h tuser=%b)",
                     results_seen, out_tdata, out_tuser);
        end else begin
          want = pending_cmds.pop_front();
          if (got.cmd_valid !== want.cmd_valid || got.verb !== want.verb ||
              got.speed !== want.speed || got.playing !== want.playing ||
              got.step !== want.step || got.loops !== want.loops ||
              got.rejected !== want.rejected) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("result %0d mismatch", results_seen);
              $display("  exp cmd=%0b verb=%0d speed=%0d play=%0b step=%0d loops=%0d rej=%0b",
                       want.cmd_valid, want.verb, want.speed, want.playing, want.step,
                       want.loops, want.rejected);
              $display("  got cmd=%0b verb=%0d speed=%0d play=%0b step=%0d loops=%0d rej=%0b",
                       got.cmd_valid, got.verb, got.speed, got.playing, got.step,
                       got.loops, got.rejected);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = predict_player(in_tuser, in_tdata[3:0],
                              {in_tdata[6:4], in_tdata[14:7], in_tdata[46:15]});
        if (row_has_exp) want = row_exp;
        pending_cmds.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm_end && !calm_out && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
      if ($urandom_range(0, 63) == 0) calm_out = !calm_out;
    end
  end

  initial begin : stim
    int          phase;
    int          n;
    int          nticks;
    logic [4:0]  p_len;
    logic [7:0]  p_tgt;
    logic        p_fwd;
    logic [2:0]  p_verb;
    logic [31:0] p_dur;
    logic [2:0]  n_op;

    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    row_has_exp = 1'b0;
    row_exp = '0;
    foreach (step_mem[i]) step_mem[i] = '0;
    running = 1'b0;
    cur_step = 0;
    loop_cnt = '0;
    elapsed = '0;
    reg_len = '0;
    reg_tgt = 8'd1;
    reg_fwd = 1'b0;
    run_len = 0;
    run_tgt = 8'd1;
    run_fwd = 1'b0;

    // idle player, empty sequence, unknown items
    plan.push_back(item_row(tspp_pkg::OP_TICK, 4'd0, VERB_FWD, 8'd0, 32'd0, 1'b1, QUIET));
    plan.push_back(item_row(tspp_pkg::OP_PLAY, 4'd0, VERB_FWD, 8'd0, 32'd0, 1'b1,
                            res(0, 0, 0, 0, 0, 0, 1)));
    plan.push_back(item_row(tspp_pkg::OP_STOP, 4'd15, tspp_pkg::VERB_COAST, 8'd255,
                            32'hFFFF_FFFF, 1'b1, res(1, tspp_pkg::VERB_COAST, 0, 0, 0, 0, 0)));
    plan.push_back(item_row(tspp_pkg::OP_BRAKE, 4'd0, VERB_FWD, 8'd255, 32'd0, 1'b1,
                            res(1, tspp_pkg::VERB_BRAKE, 0, 0, 0, 0, 0)));
    plan.push_back(item_row(OP_RSV_LO, 4'd15, tspp_pkg::VERB_COAST, 8'd255, 32'hFFFF_FFFF,
                            1'b1, QUIET));
    plan.push_back(item_row(OP_RSV_MID, 4'd0, VERB_FWD, 8'd0, 32'd0, 1'b1, QUIET));
    plan.push_back(item_row(OP_RSV_HI, 4'd5, tspp_pkg::VERB_BRAKE, 8'd17, 32'd9, 1'b1, QUIET));
    // table: drive step, brake with zero duration, far slot at extremes
    plan.push_back(item_row(tspp_pkg::OP_LOAD, 4'd0, VERB_FWD, 8'd255, 32'd2, 1'b1, QUIET));
    plan.push_back(item_row(tspp_pkg::OP_LOAD, 4'd1, tspp_pkg::VERB_BRAKE, 8'd255, 32'd0, 1'b1,
                            QUIET));
    plan.push_back(item_row(tspp_pkg::OP_LOAD, 4'd15, VERB_PIVOT_R, 8'd0, 32'hFFFF_FFFF, 1'b1,
                            QUIET));
    plan.push_back(reg_row(5'd2, 8'd2, 1'b0));
    plan.push_back(item_row(tspp_pkg::OP_PLAY, 4'd0, VERB_FWD, 8'd0, 32'd0, 1'b1,
                            res(1, VERB_FWD, 255, 1, 0, 0, 0)));
    plan.push_back(item_row(tspp_pkg::OP_LOAD, 4'd3, VERB_TURN_L, 8'd1, 32'd1, 1'b1,
                            res(0, 0, 0, 1, 0, 0, 1)));
    repeat (6) plan.push_back(item_row(tspp_pkg::OP_TICK, 4'd0, VERB_FWD, 8'd0, 32'd0, 1'b0,
                                       QUIET));
    plan.push_back(item_row(tspp_pkg::OP_PLAY, 4'd0, VERB_FWD, 8'd0, 32'd0, 1'b1,
                            res(1, VERB_FWD, 255, 1, 0, 0, 0)));
    plan.push_back(item_row(tspp_pkg::OP_STOP, 4'd0, VERB_FWD, 8'd0, 32'd0, 1'b1,
                            res(1, tspp_pkg::VERB_COAST, 0, 0, 0, 0, 0)));
    // length above the table, target zero, forever; drive step of zero length holds
    plan.push_back(reg_row(5'd31, 8'd0, 1'b1));
    plan.push_back(item_row(tspp_pkg::OP_LOAD, 4'd2, VERB_TURN_L, 8'd9, 32'd0, 1'b1, QUIET));
    plan.push_back(item_row(tspp_pkg::OP_PLAY, 4'd0, VERB_FWD, 8'd0, 32'd0, 1'b1,
                            res(1, VERB_FWD, 255, 1, 0, 0, 0)));
    repeat (4) plan.push_back(item_row(tspp_pkg::OP_TICK, 4'd0, VERB_FWD, 8'd0, 32'd0, 1'b0,
                                       QUIET));
    plan.push_back(item_row(tspp_pkg::OP_BRAKE, 4'd0, VERB_FWD, 8'd0, 32'd0, 1'b0, QUIET));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_reg_write) begin
        settle();
        write_regs(plan[i].seq_len, plan[i].loop_tgt, plan[i].loop_fwd);
      end else begin
        send_item(plan[i].op, plan[i].slot, plan[i].verb, plan[i].speed, plan[i].dur,
                  plan[i].has_exp, plan[i].exp);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < ITEMS) begin
      if (sent > ITEMS - 150) calm_end = 1'b1;
      if ($urandom_range(0, 1) == 0)
        send_item(tspp_pkg::OP_STOP, 4'd0, VERB_FWD, 8'd0, 32'd0, 1'b0, QUIET);
      else
        send_item(tspp_pkg::OP_BRAKE, 4'd0, VERB_FWD, 8'd0, 32'd0, 1'b0, QUIET);
      settle();
      case (phase)
        0: begin
          p_len = 5'd1;
          p_tgt = 8'($urandom_range(0, 255));
          p_fwd = 1'b1;
        end
        1: begin
          p_len = 5'd1;
          p_tgt = 8'd255;
          p_fwd = 1'b0;
        end
        2: begin
          p_len = 5'd31;
          p_tgt = 8'd2;
          p_fwd = 1'b0;
        end
        default: begin
          case ($urandom_range(0, 4))
            0: p_len = 5'd0;
            1: p_len = 5'd1;
            2: p_len = 5'd16;
            3: p_len = 5'($urandom_range(17, 31));
            default: p_len = 5'($urandom_range(2, 15));
          endcase
          case ($urandom_range(0, 3))
            0: p_tgt = 8'd0;
            1: p_tgt = 8'd255;
            default: p_tgt = 8'($urandom_range(1, 4));
          endcase
          p_fwd = ($urandom_range(0, 3) == 0);
        end
      endcase
      write_regs(p_len, p_tgt, p_fwd);

      if (phase == 0) begin
        p_verb = ($urandom_range(0, 1) == 0) ? tspp_pkg::VERB_COAST : tspp_pkg::VERB_BRAKE;
        send_item(tspp_pkg::OP_LOAD, 4'd0, p_verb, 8'($urandom_range(0, 255)), 32'd0,
                  1'b0, QUIET);
      end else if (phase == 1) begin
        send_item(tspp_pkg::OP_LOAD, 4'd0, tspp_pkg::VERB_BRAKE, 8'($urandom_range(0, 255)),
                  32'd1, 1'b0, QUIET);
      end else begin
        n = (p_len == 5'd0) ? 2 : ((p_len > 5'd16) ? TABLE_DEPTH : int'(p_len));
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 19))
            0, 1, 2: p_dur = 32'd0;
            3:       p_dur = 32'hFFFF_FFFF;
            4, 5:    p_dur = $urandom;
            default: p_dur = $urandom_range(1, 4);
          endcase
          if (phase == 2) p_dur = $urandom_range(1, 3);
          send_item(tspp_pkg::OP_LOAD, (p_len == 5'd0) ? 4'($urandom_range(0, 15)) : 4'(i),
                    3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), p_dur, 1'b0, QUIET);
        end
      end
      send_item(tspp_pkg::OP_PLAY, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                8'($urandom_range(0, 255)), $urandom, 1'b0, QUIET);

      case (phase)
        0: nticks = 300;
        1: nticks = 260;
        2: nticks = 120;
        default: nticks = $urandom_range(20, 90);
      endcase
      repeat (nticks) begin
        if (phase > 2 && $urandom_range(0, 99) < 12) begin
          n_op = 3'($urandom_range(tspp_pkg::OP_LOAD, OP_RSV_HI));
          send_item(n_op, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                    8'($urandom_range(0, 255)), $urandom, 1'b0, QUIET);
        end else begin
          send_item(tspp_pkg::OP_TICK, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                    8'($urandom_range(0, 255)), $urandom, 1'b0, QUIET);
        end
      end
      phase++;
    end

    settle();
    repeat (10) @(posedge clk);
    if (fail_cnt == 0 && pending_cmds.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/tspp_pkg.sv
design/timed_step_sequence_player.sv
design/tspp_checker.sv
sim/tb_top.sv
